FILE: src/sud_pkg.sv
package sud_pkg;

  localparam int MAX_WIDTH = 64;
  localparam int CNT_W = $clog2(MAX_WIDTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_FIX
  } state_t;

  typedef struct packed {
    logic        op;
    logic [1:0]  width_select;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } in_t;

  typedef struct packed {
    logic [63:0] quotient;
    logic [63:0] remainder_out;
    logic        divide_by_zero;
  } out_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic step;
    logic fix;
  } ctrl_t;

  typedef struct packed {
    logic             zero;
    logic [CNT_W-1:0] width;
  } stat_t;

  function automatic logic [CNT_W-1:0] eff_width(input logic [1:0] sel);
    int w;
    case (sel)
      2'd0: w = 8;
      2'd1: w = 16;
      2'd2: w = 32;
      default: w = 64;
    endcase
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return CNT_W'(w);
  endfunction

  function automatic logic [63:0] width_mask(input logic [CNT_W-1:0] w);
    logic [63:0] m;
    if (int'(w) >= 64) begin
      m = '1;
    end else begin
      m = (64'd1 << w) - 64'd1;
    end
    return m;
  endfunction

endpackage

FILE: src/sud_ctrl.sv
module sud_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  sud_pkg::stat_t        stat,
  output logic                  busy,
  output logic                  done,
  output sud_pkg::ctrl_t        ctrl
);

  sud_pkg::state_t               state;
  sud_pkg::state_t               state_next;
  logic [sud_pkg::CNT_W-1:0]     cnt;
  logic [sud_pkg::CNT_W-1:0]     cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sud_pkg::ST_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= ctrl.fix;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ctrl       = '0;
    busy       = 1'b1;
    case (state)
      sud_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctrl.load  = 1'b1;
          state_next = sud_pkg::ST_PREP;
        end
      end
      sud_pkg::ST_PREP: begin
        ctrl.prep = 1'b1;
        cnt_next  = stat.width;
        if (stat.zero) begin
          state_next = sud_pkg::ST_FIX;
        end else begin
          state_next = sud_pkg::ST_DIV;
        end
      end
      sud_pkg::ST_DIV: begin
        ctrl.step = 1'b1;
        cnt_next  = cnt - 1'b1;
        if (cnt == sud_pkg::CNT_W'(1)) begin
          state_next = sud_pkg::ST_FIX;
        end
      end
      sud_pkg::ST_FIX: begin
        ctrl.fix   = 1'b1;
        state_next = sud_pkg::ST_IDLE;
      end
      default: begin
        state_next = sud_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/sud_datapath.sv
module sud_datapath (
  input  logic            clk,
  input  sud_pkg::in_t    operands,
  input  sud_pkg::ctrl_t  ctrl,
  output sud_pkg::stat_t  stat,
  output sud_pkg::out_t   result
);

  logic                      op_s;
  logic [sud_pkg::CNT_W-1:0] width;
  logic [63:0]               mask;
  logic [63:0]               a_raw;
  logic [63:0]               b_raw;
  logic                      an;
  logic                      bn;
  logic [63:0]               a_sh;
  logic [63:0]               dmag;
  logic [63:0]               rem;
  logic [63:0]               q;
  logic                      zero;
  logic [5:0]                sign_idx;
  logic                      an_next;
  logic                      bn_next;
  logic [63:0]               am;
  logic [63:0]               bm;
  logic [64:0]               trial;
  logic [64:0]               diff;
  logic [sud_pkg::CNT_W-1:0] in_w;
  logic [63:0]               in_mask;

  assign in_w     = sud_pkg::eff_width(operands.width_select);
  assign in_mask  = sud_pkg::width_mask(in_w);
  assign sign_idx = 6'(width - 1'b1);
  assign an_next  = op_s & a_raw[sign_idx];
  assign bn_next  = op_s & b_raw[sign_idx];
  assign am       = an_next ? ((64'd0 - a_raw) & mask) : a_raw;
  assign bm       = bn_next ? ((64'd0 - b_raw) & mask) : b_raw;
  assign trial    = {rem, a_sh[63]};
  assign diff     = trial - {1'b0, dmag};

  assign stat.zero  = (b_raw == 64'd0);
  assign stat.width = width;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op_s  <= operands.op;
      width <= in_w;
      mask  <= in_mask;
      a_raw <= operands.dividend & in_mask;
      b_raw <= operands.divisor & in_mask;
    end
    if (ctrl.prep) begin
      an   <= an_next;
      bn   <= bn_next;
      a_sh <= am << (7'd64 - 7'(width));
      dmag <= bm;
      rem  <= '0;
      q    <= '0;
      zero <= stat.zero;
    end
    if (ctrl.step) begin
      a_sh <= {a_sh[62:0], 1'b0};
      q    <= {q[62:0], ~diff[64]};
      rem  <= diff[64] ? trial[63:0] : diff[63:0];
    end
    if (ctrl.fix) begin
      result.divide_by_zero <= zero;
      if (zero) begin
        result.quotient      <= '0;
        result.remainder_out <= a_raw;
      end else begin
        result.quotient      <= ((an ^ bn) ? (64'd0 - q) : q) & mask;
        result.remainder_out <= (an ? (64'd0 - rem) : rem) & mask;
      end
    end
  end

endmodule

FILE: src/signed_unsigned_divider.sv
// Signed and unsigned integer divider for 8, 16, 32 or 64 bit operands. An
// operand beat is taken when start is high and busy is low. The PREP state
// prepares the operand magnitudes, the shift-subtract loop then retires one
// quotient bit per cycle for the selected width W (skipped for a zero
// divisor), and the FIX state applies signs. The result beat is then shown
// with done high for exactly one cycle. The receiver cannot hold it off and
// must capture it in that cycle. A new beat may be started in the cycle in
// which the previous result is shown; busy stays high until then, so a new
// beat is not taken while the previous one is still in progress.
module signed_unsigned_divider (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  sud_pkg::in_t   operands,
  output logic           busy,
  output logic           done,
  output sud_pkg::out_t  result
);

  sud_pkg::ctrl_t ctrl;
  sud_pkg::stat_t stat;

  sud_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .done  (done),
    .ctrl  (ctrl)
  );

  sud_datapath u_datapath (
    .clk      (clk),
    .operands (operands),
    .ctrl     (ctrl),
    .stat     (stat),
    .result   (result)
  );

endmodule
